/* design/fwwt_pkg.sv */
`timescale 1ns / 1ps

package fwwt_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FAULT   = 2'd2,
        ST_AGAIN   = 2'd3
    } status_t;

    // Request opcodes.
    localparam logic OP_WAIT = 1'b0;
    localparam logic OP_WAKE = 1'b1;

    // A futex word must be four-byte aligned.
    localparam logic [1:0] ALIGN_MASK = 2'b11;

    // Most results one wake request may return.
    localparam logic [4:0] MAX_RESULTS = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST
    } seq_state_t;

    // Commands from the sequencer to the slot table.
    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } tbl_cmd_t;

endpackage

/* design/fwwt_slot_table.sv */
`timescale 1ns / 1ps

module fwwt_slot_table
    import fwwt_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_W     = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_cmd_t          cmd,
    input  logic [SLOT_W-1:0] wr_idx,
    input  logic [7:0]        wr_dom,
    input  logic [63:0]       wr_addr,
    input  logic [SLOT_W-1:0] rd_idx,
    input  logic [7:0]        cmp_dom,
    input  logic [63:0]       cmp_addr,
    output logic              match
);

    logic [SLOT_COUNT-1:0] waiting_reg;
    logic [SLOT_COUNT-1:0] waiting_next;
    logic [7:0]            dom_reg  [SLOT_COUNT];
    logic [63:0]           addr_reg [SLOT_COUNT];

    always_comb
    begin
        waiting_next = waiting_reg;
        if (cmd.clr_en)
        begin
            waiting_next[rd_idx] = 1'b0;
        end
        if (cmd.wr_en)
        begin
            waiting_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= '0;
        end
        else
        begin
            waiting_reg <= waiting_next;
        end
    end

    // Domain and address only count while the waiting flag is set.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            dom_reg[wr_idx]  <= wr_dom;
            addr_reg[wr_idx] <= wr_addr;
        end
    end

    // The one shared comparator: the slot under the scan against the request.
    assign match = waiting_reg[rd_idx] && (dom_reg[rd_idx] == cmp_dom)
                   && (addr_reg[rd_idx] == cmp_addr);

endmodule

/* design/fwwt_sequencer.sv */
`timescale 1ns / 1ps

module fwwt_sequencer
    import fwwt_pkg::*;
#(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_W     = 4,
    parameter int CNT_W      = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic              misaligned,
    input  status_t           wait_status,
    input  logic [31:0]       wake_limit,
    output tbl_cmd_t          cmd,
    output logic [SLOT_W-1:0] scan_idx,
    input  logic              match,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic              woken_valid,
    output logic [3:0]        woken_slot,
    output logic [4:0]        woken_count,
    output logic              last
);

    seq_state_t state_reg, state_next;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [4:0]       woke_reg, woke_next;
    logic [31:0]      limit_reg, limit_next;

    status_t          pend_status_reg, pend_status_next;
    logic             pend_wv_reg, pend_wv_next;
    logic [3:0]       pend_slot_reg, pend_slot_next;
    logic [4:0]       pend_count_reg, pend_count_next;

    logic             out_valid_reg, out_valid_next;
    status_t          out_status_reg, out_status_next;
    logic             out_wv_reg, out_wv_next;
    logic [3:0]       out_slot_reg, out_slot_next;
    logic [4:0]       out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;

    logic             in_accept;
    logic             out_free;
    logic             stop;
    logic             advance;
    logic             load_out;
    logic [CNT_W+3:0] idx_ext;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_idx  = idx_reg[SLOT_W-1:0];
    assign idx_ext   = {4'b0, idx_reg};

    assign stop = (idx_reg == CNT_W'(SLOT_COUNT)) || ({27'b0, woke_reg} >= limit_reg)
                  || (woke_reg >= MAX_RESULTS);
    // A hit while a result is already held can only proceed once that result has somewhere to go.
    assign advance = !stop && (!match || !pend_wv_reg || out_free);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode == OP_WAIT || misaligned || wake_limit == 32'd0)
                    begin
                        state_next = S_LAST;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (stop)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next         = idx_reg;
        woke_next        = woke_reg;
        limit_next       = limit_reg;
        pend_status_next = pend_status_reg;
        pend_wv_next     = pend_wv_reg;
        pend_slot_next   = pend_slot_reg;
        pend_count_next  = pend_count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_wv_next      = out_wv_reg;
        out_slot_next    = out_slot_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;
        cmd              = '0;
        load_out         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next        = '0;
                    woke_next       = '0;
                    limit_next      = wake_limit;
                    pend_wv_next    = 1'b0;
                    pend_slot_next  = '0;
                    pend_count_next = '0;
                    if (opcode == OP_WAIT)
                    begin
                        pend_status_next = wait_status;
                        cmd.wr_en        = (wait_status == ST_OK);
                    end
                    else
                    begin
                        pend_status_next = misaligned ? ST_INVALID : ST_OK;
                    end
                end
            end
            S_SCAN:
            begin
                if (advance)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                    if (match)
                    begin
                        cmd.clr_en = 1'b1;
                        if (pend_wv_reg)
                        begin
                            load_out        = 1'b1;
                            out_valid_next  = 1'b1;
                            out_status_next = pend_status_reg;
                            out_wv_next     = 1'b1;
                            out_slot_next   = pend_slot_reg;
                            out_count_next  = pend_count_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_wv_next    = 1'b1;
                        pend_slot_next  = idx_ext[3:0];
                        pend_count_next = woke_reg + 5'd1;
                        woke_next       = woke_reg + 5'd1;
                    end
                end
            end
            S_LAST:
            begin
                if (out_free)
                begin
                    load_out        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_wv_next     = pend_wv_reg;
                    out_slot_next   = pend_slot_reg;
                    out_count_next  = pend_count_reg;
                    out_last_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        woke_reg        <= woke_next;
        limit_reg       <= limit_next;
        pend_status_reg <= pend_status_next;
        pend_wv_reg     <= pend_wv_next;
        pend_slot_reg   <= pend_slot_next;
        pend_count_reg  <= pend_count_next;
        out_status_reg  <= out_status_next;
        out_wv_reg      <= out_wv_next;
        out_slot_reg    <= out_slot_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign woken_valid = out_wv_reg;
    assign woken_slot  = out_slot_reg;
    assign woken_count = out_count_reg;
    assign last        = out_last_reg;

    // A new beat is only loaded when the previous one has gone or is going.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> out_free)
        else $error("output beat overwritten before it was taken");

    // The table is never written and cleared in the same cycle.
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.clr_en))
        else $error("slot table written and cleared together");

    // During a scan the held result always carries the running wake count.
    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (pend_count_reg == woke_reg))
        else $error("held result count differs from wake count");

    // The wake count never passes the result cap.
    a_woke_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (woke_reg <= MAX_RESULTS))
        else $error("wake count passed the result cap");

endmodule

/* design/futex_wait_wake_table.sv */
`timescale 1ns / 1ps

// Futex wait and wake table for SLOT_COUNT thread slots.
//
// Requests arrive on the in_valid / in_ready channel, one beat per request,
// and results leave on the out_valid / out_ready channel. A wait request and
// any wake request that is rejected, has a zero limit or wakes nobody give
// exactly one result beat with last set. A wake request that frees waiters
// gives one beat per woken slot, in ascending slot order, the final one
// marked with last.
//
// A wait passes from acceptance through the S_LAST state into the output
// register. A wake walks the slots one per cycle, except where a hit waits on
// a stalled receiver, through a single shared comparator while in_ready stays
// low; the scan stops early once the limit is reached.
//
// The result sits in an output register. If the receiver stalls, the scan
// holds on the next hit until that register has been taken, so no beat is
// lost. Reset clears every waiting flag at once; no clearing pass is needed.
module futex_wait_wake_table
    import fwwt_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [3:0]  thread_slot,
    input  logic [7:0]  domain_id,
    input  logic [63:0] word_address,
    input  logic [31:0] expected_value,
    input  logic [31:0] memory_word,
    input  logic        access_ok,
    input  logic [31:0] wake_limit,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic        woken_valid,
    output logic [3:0]  woken_slot,
    output logic [4:0]  woken_count,
    output logic        last
);

    // Slot index width, and a scan counter wide enough to hold SLOT_COUNT.
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

    logic               misaligned;
    logic               slot_oob;
    status_t            wait_status;
    logic [SLOT_W+3:0]  ts_ext;
    logic [SLOT_W-1:0]  wr_idx;
    logic [SLOT_W-1:0]  scan_idx;
    logic               match;
    tbl_cmd_t           cmd;
    logic               in_accept;

    // The request's domain and address are held for the whole scan.
    logic [7:0]         req_dom_reg;
    logic [63:0]        req_addr_reg;

    assign in_accept  = in_valid && in_ready;
    assign misaligned = (word_address[1:0] & ALIGN_MASK) != 2'b00;
    assign slot_oob   = 32'(thread_slot) >= 32'(SLOT_COUNT);
    assign ts_ext     = {{SLOT_W{1'b0}}, thread_slot};
    assign wr_idx     = ts_ext[SLOT_W-1:0];

    // Wait checks in priority order: alignment and slot range, then the
    // memory access, then the value comparison.
    always_comb
    begin
        if (misaligned || slot_oob)
        begin
            wait_status = ST_INVALID;
        end
        else if (!access_ok)
        begin
            wait_status = ST_FAULT;
        end
        else if (memory_word != expected_value)
        begin
            wait_status = ST_AGAIN;
        end
        else
        begin
            wait_status = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_dom_reg  <= domain_id;
            req_addr_reg <= word_address;
        end
    end

    fwwt_slot_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_idx   (wr_idx),
        .wr_dom   (domain_id),
        .wr_addr  (word_address),
        .rd_idx   (scan_idx),
        .cmp_dom  (req_dom_reg),
        .cmp_addr (req_addr_reg),
        .match    (match)
    );

    fwwt_sequencer #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .misaligned  (misaligned),
        .wait_status (wait_status),
        .wake_limit  (wake_limit),
        .cmd         (cmd),
        .scan_idx    (scan_idx),
        .match       (match),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .woken_valid (woken_valid),
        .woken_slot  (woken_slot),
        .woken_count (woken_count),
        .last        (last)
    );

endmodule
